// ----- design/fba_pkg.sv -----
// ----------------------------------------------------------------------------
// fba_pkg
// shared codes, widths and types for the fit block allocator
// ----------------------------------------------------------------------------
package fba_pkg;

    // fixed field widths of the command, result and config ports
    localparam int OP_W        = 2;
    localparam int INDEX_W     = 7;
    localparam int POLICY_W    = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;

    // command codes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // fit policy codes, the unused code acts as first fit
    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FIT_POLICY  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 1'd1;

    // decision of the compare unit for one scanned entry
    typedef struct packed {
        logic fits;
        logic take;
    } fit_dec_t;

endpackage

// ----- design/fba_fit_unit.sv -----
// ----------------------------------------------------------------------------
// fba_fit_unit
// shared compare unit: decides whether a scanned block replaces the pick
// ----------------------------------------------------------------------------
module fba_fit_unit #(
    parameter int SIZE_BITS = 32
) (
    input  logic                         cand_valid,
    input  logic                         cand_in_use,
    input  logic [SIZE_BITS-1:0]         cand_size,
    input  logic [SIZE_BITS-1:0]         request,
    input  logic [fba_pkg::POLICY_W-1:0] policy,
    input  logic                         have_pick,
    input  logic [SIZE_BITS-1:0]         pick_size,
    output fba_pkg::fit_dec_t            dec
);

    logic fits;
    logic smaller;
    logic larger;

    assign fits    = cand_valid && !cand_in_use && (cand_size >= request);
    assign smaller = cand_size < pick_size;
    assign larger  = cand_size > pick_size;

    always_comb
    begin
        dec.fits = fits;
        case (policy)
            fba_pkg::POLICY_BEST:
            begin
                dec.take = fits && (!have_pick || smaller);
            end
            fba_pkg::POLICY_WORST:
            begin
                dec.take = fits && (!have_pick || larger);
            end
            default:
            begin
                // first fit: only the lowest fitting block
                dec.take = fits && !have_pick;
            end
        endcase
    end

endmodule

// ----- design/fit_block_allocator.sv -----
// ----------------------------------------------------------------------------
// fit_block_allocator
// fixed-block memory allocator with first, best and worst fit policies
// ----------------------------------------------------------------------------
//
// channel   | ports                                      | transfer when
// ----------+--------------------------------------------+-------------------
// command   | start, busy, op, block_index, size_value   | start && !busy
// result    | done, granted, block_number                | done (one cycle)
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data  | cfg_valid && cfg_ready
//
// load, clear and unused commands finish in the cycle they are taken, busy
// stays low
// an allocate keeps busy high while it reads the active blocks one by one
// through the single read port of the size memory and the shared compare
// unit, drains the read pipeline and marks the pick (with no active blocks
// it goes straight to the mark); done pulses in the cycle after the mark
// reset clears the in-use marks, both config registers and the sequencer;
// block sizes are undefined until loaded
// the receiver cannot stall: each result shows for exactly one cycle
// ----------------------------------------------------------------------------
module fit_block_allocator #(
    parameter int MAX_BLOCKS = 64,
    parameter int SIZE_BITS  = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // command channel
    input  logic                            start,
    output logic                            busy,
    input  logic [fba_pkg::OP_W-1:0]        op,
    input  logic [fba_pkg::INDEX_W-1:0]     block_index,
    input  logic [SIZE_BITS-1:0]            size_value,

    // result channel
    output logic                            done,
    output logic                            granted,
    output logic [fba_pkg::INDEX_W-1:0]     block_number,

    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fba_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fba_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_EXT_W = (ADDR_W > fba_pkg::INDEX_W) ? ADDR_W : fba_pkg::INDEX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_DONE
    } state_t;

    state_t                       state_reg;

    // configuration
    logic [fba_pkg::POLICY_W-1:0] policy_reg;
    logic [fba_pkg::INDEX_W-1:0]  count_reg;

    // block table
    logic [SIZE_BITS-1:0]         size_mem [MAX_BLOCKS];
    logic [SIZE_BITS-1:0]         rd_data_reg;
    logic [MAX_BLOCKS-1:0]        in_use_reg;

    // scan datapath
    logic [SIZE_BITS-1:0]         req_reg;
    logic [ADDR_W-1:0]            addr_reg;
    logic [ADDR_W-1:0]            last_reg;
    logic [ADDR_W-1:0]            cmp_idx_reg;
    logic                         cmp_valid_reg;
    logic                         use_bit_reg;
    logic                         have_reg;
    logic [ADDR_W-1:0]            chosen_reg;
    logic [SIZE_BITS-1:0]         best_reg;

    // registered result
    logic                         done_reg;
    logic                         granted_reg;
    logic [fba_pkg::INDEX_W-1:0]  number_reg;

    logic                         cmd_take;
    logic                         load_ok;
    logic [IDX_EXT_W-1:0]         load_addr_full;
    logic [ADDR_W-1:0]            load_addr;
    logic                         mem_we;
    logic [CNT_W-1:0]             active_cnt;
    logic [ADDR_W-1:0]            last_addr;
    logic                         scanning;
    fba_pkg::fit_dec_t            dec;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign cmd_take  = start && !busy;

    assign done         = done_reg;
    assign granted      = granted_reg;
    assign block_number = number_reg;

    // load index check and 0-based table address
    assign load_ok        = (block_index != '0)
                            && (32'(block_index) <= 32'(MAX_BLOCKS));
    assign load_addr_full = IDX_EXT_W'(block_index) - IDX_EXT_W'(1);
    assign load_addr      = load_addr_full[ADDR_W-1:0];
    assign mem_we         = cmd_take && (op == fba_pkg::OP_LOAD) && load_ok;

    // block count above the table depth is clipped to the depth
    always_comb
    begin
        if (32'(count_reg) > 32'(MAX_BLOCKS))
        begin
            active_cnt = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            active_cnt = CNT_W'(count_reg);
        end
    end

    assign last_addr = ADDR_W'(active_cnt - CNT_W'(1));
    assign scanning  = (state_reg == S_SCAN) || (state_reg == S_LAST);

    // one compare unit judges the entry read in the previous cycle
    fba_fit_unit #(
        .SIZE_BITS (SIZE_BITS)
    ) u_fit_unit (
        .cand_valid  (cmp_valid_reg),
        .cand_in_use (use_bit_reg),
        .cand_size   (rd_data_reg),
        .request     (req_reg),
        .policy      (policy_reg),
        .have_pick   (have_reg),
        .pick_size   (best_reg),
        .dec         (dec)
    );

    // size table: one write port for loads, one registered read for the scan
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            size_mem[load_addr] <= size_value;
        end
        rd_data_reg <= size_mem[addr_reg];
    end

    // scan datapath, no reset needed
    always_ff @(posedge clk)
    begin
        use_bit_reg <= in_use_reg[addr_reg];
        cmp_idx_reg <= addr_reg;
        if (cmd_take && (op == fba_pkg::OP_ALLOC))
        begin
            req_reg  <= size_value;
            addr_reg <= '0;
            last_reg <= last_addr;
        end
        else if ((state_reg == S_SCAN) && (addr_reg != last_reg))
        begin
            addr_reg <= addr_reg + ADDR_W'(1);
        end
        if (scanning && dec.take)
        begin
            chosen_reg <= cmp_idx_reg;
            best_reg   <= rd_data_reg;
        end
    end

    // sequencer, configuration, in-use marks and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            policy_reg    <= fba_pkg::POLICY_FIRST;
            count_reg     <= '0;
            in_use_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            have_reg      <= 1'b0;
            done_reg      <= 1'b0;
            granted_reg   <= 1'b0;
            number_reg    <= '0;
        end
        else
        begin
            done_reg      <= 1'b0;
            cmp_valid_reg <= (state_reg == S_SCAN);

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fba_pkg::REG_FIT_POLICY:
                    begin
                        policy_reg <= cfg_data[fba_pkg::POLICY_W-1:0];
                    end
                    fba_pkg::REG_BLOCK_COUNT:
                    begin
                        count_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        case (op)
                            fba_pkg::OP_LOAD:
                            begin
                                // a reloaded block is free again
                                if (load_ok)
                                begin
                                    in_use_reg[load_addr] <= 1'b0;
                                end
                            end
                            fba_pkg::OP_CLEAR:
                            begin
                                in_use_reg <= '0;
                            end
                            fba_pkg::OP_ALLOC:
                            begin
                                have_reg <= 1'b0;
                                // no active blocks: answer at once with no fit
                                if (active_cnt == '0)
                                begin
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (dec.take)
                    begin
                        have_reg <= 1'b1;
                    end
                    if (addr_reg == last_reg)
                    begin
                        state_reg <= S_LAST;
                    end
                end
                S_LAST:
                begin
                    // last read entry comes out of the pipeline here
                    if (dec.take)
                    begin
                        have_reg <= 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (have_reg)
                    begin
                        in_use_reg[chosen_reg] <= 1'b1;
                        number_reg <= fba_pkg::INDEX_W'(CNT_W'(chosen_reg) + CNT_W'(1));
                    end
                    else
                    begin
                        number_reg <= '0;
                    end
                    granted_reg <= have_reg;
                    done_reg    <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- sim/fit_block_checker.sv -----
// ----------------------------------------------------------------------------
// fit_block_checker
// watches the command, result and config channels of the fit block allocator,
// keeps its own copy of the block table and checks every allocate result
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fit_block_checker #(
    parameter int MAX_BLOCKS = 64,
    parameter int SIZE_BITS  = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [fba_pkg::OP_W-1:0]        op,
    input  logic [fba_pkg::INDEX_W-1:0]     block_index,
    input  logic [SIZE_BITS-1:0]            size_value,
    input  logic                            done,
    input  logic                            granted,
    input  logic [fba_pkg::INDEX_W-1:0]     block_number,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [fba_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fba_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              errors,
    output int                              pending
);

    typedef struct packed {
        logic                        granted;
        logic [fba_pkg::INDEX_W-1:0] number;
    } grant_t;

    grant_t                         grant_q[$];
    logic [SIZE_BITS-1:0]           sizes [MAX_BLOCKS];
    bit                             used [MAX_BLOCKS];
    logic [fba_pkg::POLICY_W-1:0]   policy;
    logic [fba_pkg::CFG_DATA_W-1:0] count;
    int                             fails;

    // 1-based block picked for a request, 0 when nothing fits
    function automatic int find_fit(input logic [SIZE_BITS-1:0] request);
        int                   live;
        int                   pick;
        int                   k;
        logic [SIZE_BITS-1:0] pick_size;
        live = (count > MAX_BLOCKS) ? MAX_BLOCKS : int'(count);
        pick = 0;
        pick_size = '0;
        for (k = 0; k < live; k++)
        begin
            if (!used[k] && sizes[k] >= request)
            begin
                if (policy == fba_pkg::POLICY_BEST)
                begin
                    if (pick == 0 || sizes[k] < pick_size)
                    begin
                        pick = k + 1;
                        pick_size = sizes[k];
                    end
                end
                else if (policy == fba_pkg::POLICY_WORST)
                begin
                    if (pick == 0 || sizes[k] > pick_size)
                    begin
                        pick = k + 1;
                        pick_size = sizes[k];
                    end
                end
                else if (pick == 0)
                begin
                    pick = k + 1;
                end
            end
        end
        return pick;
    endfunction

    task automatic flag(input string what, input int want_v, input int got_v);
        fails++;
        if (fails <= 10)
            $display("%0t fit check: %s expected %0d got %0d", $realtime, what, want_v, got_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        grant_t want;
        int     pick;
        if (!rst_n)
        begin
            foreach (used[k])
                used[k] = 1'b0;
            policy = fba_pkg::POLICY_FIRST;
            count = '0;
            fails = 0;
            grant_q.delete();
            pending <= 0;
            errors <= 0;
        end
        else
        begin
            // result first, a new allocate can only add to the back
            if (done)
            begin
                if (grant_q.size() == 0)
                    flag("result with no open allocate, block_number", 0, block_number);
                else
                begin
                    want = grant_q.pop_front();
                    if (granted !== want.granted)
                        flag("granted", want.granted, granted);
                    if (block_number !== want.number)
                        flag("block_number", want.number, block_number);
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == fba_pkg::REG_FIT_POLICY)
                    policy = cfg_data[fba_pkg::POLICY_W-1:0];
                else
                    count = cfg_data;
            end

            if (start && !busy)
            begin
                case (op)
                    fba_pkg::OP_LOAD:
                    begin
                        if (block_index >= 1 && block_index <= MAX_BLOCKS)
                        begin
                            sizes[block_index-1] = size_value;
                            used[block_index-1] = 1'b0;
                        end
                    end
                    fba_pkg::OP_CLEAR:
                    begin
                        foreach (used[k])
                            used[k] = 1'b0;
                    end
                    fba_pkg::OP_ALLOC:
                    begin
                        pick = find_fit(size_value);
                        if (pick != 0)
                            used[pick-1] = 1'b1;
                        want.granted = (pick != 0);
                        want.number = fba_pkg::INDEX_W'(pick);
                        grant_q.push_back(want);
                    end
                    default:
                    begin
                    end
                endcase
            end

            pending <= grant_q.size();
            errors <= fails;
        end
    end

endmodule

// ----- sim/tb_fit_block_allocator.sv -----
// ----------------------------------------------------------------------------
// tb_fit_block_allocator
// drives load, allocate, clear and unused commands and config writes into
// the fit block allocator under several policies and block counts; a
// checker beside the block predicts every grant and counts mismatches
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_fit_block_allocator;

    localparam int MAX_BLOCKS   = 64;
    localparam int SIZE_BITS    = 32;
    // wait that outlasts an allocate over all 64 blocks, plus some margin
    localparam int DRAIN_CYCLES = 70;
    // cycles without any transfer before the run is given up
    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 160;

    // codes the package leaves unnamed
    localparam logic [fba_pkg::OP_W-1:0]     OP_UNUSED    = 2'd3;
    localparam logic [fba_pkg::POLICY_W-1:0] POLICY_SPARE = 2'd3;
    localparam logic [SIZE_BITS-1:0]         SIZE_FULL    = '1;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic [fba_pkg::OP_W-1:0]        op = fba_pkg::OP_LOAD;
    logic [fba_pkg::INDEX_W-1:0]     block_index = '0;
    logic [SIZE_BITS-1:0]            size_value = '0;
    logic                            done;
    logic                            granted;
    logic [fba_pkg::INDEX_W-1:0]     block_number;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [fba_pkg::CFG_INDEX_W-1:0] cfg_index = fba_pkg::REG_FIT_POLICY;
    logic [fba_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    int                              errors;
    int                              pending;

    // stimulus-side bookkeeping, used only to shape requests
    int                              idle_pct = 0;
    logic [fba_pkg::CFG_DATA_W-1:0]  cur_count = '0;
    bit                              loaded [MAX_BLOCKS];
    logic [SIZE_BITS-1:0]            shadow [MAX_BLOCKS];

    // policy and block count per random phase: small counts mostly, the
    // extremes and the out-of-range counts among them
    logic [fba_pkg::POLICY_W-1:0]   phase_policy [PHASES] = '{fba_pkg::POLICY_FIRST,
        fba_pkg::POLICY_BEST, fba_pkg::POLICY_WORST, POLICY_SPARE, fba_pkg::POLICY_BEST,
        fba_pkg::POLICY_WORST, fba_pkg::POLICY_FIRST, fba_pkg::POLICY_BEST,
        fba_pkg::POLICY_WORST, fba_pkg::POLICY_BEST, POLICY_SPARE, fba_pkg::POLICY_FIRST};
    logic [fba_pkg::CFG_DATA_W-1:0] phase_count [PHASES] = '{7'd8, 7'd16, 7'd64, 7'd3,
        7'd127, 7'd1, 7'd100, 7'd0, 7'd5, 7'd64, 7'd65, 7'd12};

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    fit_block_allocator #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .block_index  (block_index),
        .size_value   (size_value),
        .done         (done),
        .granted      (granted),
        .block_number (block_number),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    fit_block_checker #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .block_index  (block_index),
        .size_value   (size_value),
        .done         (done),
        .granted      (granted),
        .block_number (block_number),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending)
    );

    // one register write; valid drops for a cycle after the transfer so that
    // back-to-back writes never lower and raise it in the same step
    task automatic cfg_write(input logic [fba_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [fba_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == fba_pkg::REG_BLOCK_COUNT)
            cur_count = data;
        @(posedge clk);
    endtask

    // one command transfer, with an optional sender gap in front;
    // returns at the edge that takes the command
    task automatic issue(input logic [fba_pkg::OP_W-1:0] c,
                         input logic [fba_pkg::INDEX_W-1:0] idx,
                         input logic [SIZE_BITS-1:0] sz);
        int gap;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            // mostly short gaps, now and then one long enough to outlast a scan
            gap = ($urandom_range(7) == 0) ? $urandom_range(4, DRAIN_CYCLES)
                                           : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        op <= c;
        block_index <= idx;
        size_value <= sz;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (c == fba_pkg::OP_LOAD && idx >= 1 && idx <= MAX_BLOCKS)
        begin
            loaded[idx-1] = 1'b1;
            shadow[idx-1] = sz;
        end
    endtask

    // block goes idle: no grant outstanding, then room for a silent command
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // policy write carries random upper data bits, only the low two count
    task automatic set_phase(input logic [fba_pkg::POLICY_W-1:0] pol,
                             input logic [fba_pkg::CFG_DATA_W-1:0] cnt);
        settle();
        cfg_write(fba_pkg::REG_FIT_POLICY, {5'($urandom_range(31)), pol});
        cfg_write(fba_pkg::REG_BLOCK_COUNT, cnt);
    endtask

    task automatic random_item();
        int                          live;
        int                          roll;
        int                          k;
        int                          hole;
        logic [fba_pkg::OP_W-1:0]    c;
        logic [fba_pkg::INDEX_W-1:0] idx;
        logic [SIZE_BITS-1:0]        sz;
        logic [SIZE_BITS-1:0]        base;
        live = (cur_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(cur_count);
        roll = $urandom_range(99);
        // index and size are don't-care outside loads and allocates
        idx = fba_pkg::INDEX_W'($urandom_range(127));
        sz = $urandom();
        c = OP_UNUSED;
        if (roll < 30)
        begin
            // load, mostly inside the active range; small sizes give ties
            c = fba_pkg::OP_LOAD;
            if (live != 0 && $urandom_range(3) != 0)
                idx = fba_pkg::INDEX_W'($urandom_range(1, live));
            else
                idx = fba_pkg::INDEX_W'($urandom_range(1, MAX_BLOCKS));
            case ($urandom_range(9))
                0, 1, 2, 3, 4: sz = $urandom_range(15);
                5, 6:          sz = $urandom();
                7:             sz = SIZE_FULL;
                8:             sz = '0;
                default:       sz = $urandom() >> $urandom_range(31);
            endcase
        end
        else if (roll < 85)
        begin
            // an allocate must never scan a block that was never loaded,
            // so fill the lowest hole in the active range first
            hole = 0;
            for (k = live; k >= 1; k--)
                if (!loaded[k-1])
                    hole = k;
            if (hole != 0)
            begin
                c = fba_pkg::OP_LOAD;
                idx = fba_pkg::INDEX_W'(hole);
                sz = $urandom_range(15);
            end
            else
            begin
                c = fba_pkg::OP_ALLOC;
                base = (live != 0) ? shadow[$urandom_range(live - 1)] : $urandom_range(15);
                // requests near existing sizes hit exact fits and boundaries
                case ($urandom_range(9))
                    0, 1, 2, 3: sz = base;
                    4:          sz = base + 1'b1;
                    5:          sz = base - 1'b1;
                    6:          sz = $urandom();
                    7:          sz = '0;
                    8:          sz = SIZE_FULL;
                    default:    sz = $urandom_range(16);
                endcase
            end
        end
        else if (roll < 93)
            c = fba_pkg::OP_CLEAR;
        else if (roll < 97)
        begin
            // load with an index outside the table, ignored by the block
            c = fba_pkg::OP_LOAD;
            idx = $urandom_range(1) ? fba_pkg::INDEX_W'(0)
                                    : fba_pkg::INDEX_W'($urandom_range(MAX_BLOCKS + 1, 127));
        end
        issue(c, idx, sz);
    endtask

    // watchdog: any command, result or config transfer restarts the count
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_fit_block_allocator: errors");
        $finish;
    end

    initial
    begin : stimulus
        int p;
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: best fit over four blocks
        set_phase(fba_pkg::POLICY_BEST, 7'd4);
        issue(fba_pkg::OP_LOAD, 7'd1, SIZE_FULL);
        issue(fba_pkg::OP_LOAD, 7'd2, 32'd100);
        issue(fba_pkg::OP_LOAD, 7'd3, '0);
        issue(fba_pkg::OP_LOAD, 7'd4, 32'd100);
        // out-of-table loads are dropped, a load past the count is kept
        issue(fba_pkg::OP_LOAD, 7'd0, 32'd5);
        issue(fba_pkg::OP_LOAD, 7'd65, 32'd5);
        issue(fba_pkg::OP_LOAD, 7'd127, 32'd5);
        issue(fba_pkg::OP_LOAD, 7'd64, 32'd7);
        issue(OP_UNUSED, 7'd127, SIZE_FULL);
        // full-size block taken by best fit, then a tie to the lower block
        issue(fba_pkg::OP_ALLOC, 7'd0, SIZE_FULL);
        issue(fba_pkg::OP_ALLOC, 7'd127, 32'd100);
        issue(fba_pkg::OP_ALLOC, 7'd0, 32'd100);
        // no fit, then a zero request, then everything in use
        issue(fba_pkg::OP_ALLOC, 7'd0, 32'd100);
        issue(fba_pkg::OP_ALLOC, 7'd0, '0);
        issue(fba_pkg::OP_ALLOC, 7'd0, '0);
        issue(fba_pkg::OP_CLEAR, 7'd127, SIZE_FULL);
        issue(fba_pkg::OP_ALLOC, 7'd0, 32'd1);

        // worst fit prefers the full-size block
        set_phase(fba_pkg::POLICY_WORST, 7'd4);
        issue(fba_pkg::OP_ALLOC, 7'd0, 32'd1);
        issue(fba_pkg::OP_ALLOC, 7'd0, 32'd1);
        // spare policy code behaves as first fit
        set_phase(POLICY_SPARE, 7'd4);
        issue(fba_pkg::OP_ALLOC, 7'd0, '0);
        // zero active blocks never grant
        set_phase(fba_pkg::POLICY_FIRST, 7'd0);
        issue(fba_pkg::OP_ALLOC, 7'd0, '0);

        // random phases: sender idles at 23 percent, then 65, then never
        for (p = 0; p < PHASES; p++)
        begin
            idle_pct = (p < 4) ? 23 : (p < 8) ? 65 : 0;
            set_phase(phase_policy[p], phase_count[p]);
            for (n = 0; n < PHASE_ITEMS; n++)
                random_item();
        end

        settle();
        if (errors == 0)
            $display("tb_fit_block_allocator: clean");
        else
            $display("tb_fit_block_allocator: errors");
        $finish;
    end

endmodule
